/* design/deq_pkg.sv */
// Shared types and codes for the double-ended queue.
// Used by deq_ctrl, deq_dp and double_ended_queue; no dependencies.
package deq_pkg;

  // request codes carried on in_tuser
  localparam logic [2:0] FN_PUSH_BACK  = 3'd0;
  localparam logic [2:0] FN_PUSH_FRONT = 3'd1;
  localparam logic [2:0] FN_POP_FRONT  = 3'd2;
  localparam logic [2:0] FN_POP_BACK   = 3'd3;
  localparam logic [2:0] FN_FRONT      = 3'd4;
  localparam logic [2:0] FN_BACK       = 3'd5;
  localparam logic [2:0] FN_SIZE       = 3'd6;
  localparam logic [2:0] FN_CLEAR      = 3'd7;

  // result status carried on out_tuser
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DATA  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // source of a result beat
  localparam logic [1:0] SRC_OK   = 2'd0;
  localparam logic [1:0] SRC_ERR  = 2'd1;
  localparam logic [1:0] SRC_SIZE = 2'd2;
  localparam logic [1:0] SRC_MEM  = 2'd3;

  typedef struct packed {
    logic       put_back;
    logic       put_front;
    logic       take_front;
    logic       take_back;
    logic       clear;
    logic       rd_en;
    logic       rd_back;
    logic       ld_res;
    logic [1:0] res_src;
  } deq_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } deq_stat_t;

endpackage

/* design/deq_ctrl.sv */
// Request sequencer for the double-ended queue: handshakes and command decode.
// Depends on deq_pkg.
module deq_ctrl
  import deq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [2:0] in_func,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  deq_stat_t  stat,
  output deq_cmd_t   cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic acc;

  // sequencer is idle and the output register is free, or drains this cycle
  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd       = '0;
    cmd.res_src = SRC_OK;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (in_func) inside
            FN_PUSH_BACK, FN_PUSH_FRONT: begin
              cmd.ld_res = 1'b1;
              if (stat.full) begin
                cmd.res_src = SRC_ERR;
              end else begin
                cmd.put_back  = (in_func == FN_PUSH_BACK);
                cmd.put_front = (in_func == FN_PUSH_FRONT);
              end
            end
            FN_POP_FRONT, FN_POP_BACK, FN_FRONT, FN_BACK: begin
              if (stat.empty) begin
                cmd.ld_res  = 1'b1;
                cmd.res_src = SRC_ERR;
              end else begin
                cmd.rd_en      = 1'b1;
                cmd.rd_back    = (in_func == FN_POP_BACK) || (in_func == FN_BACK);
                cmd.take_front = (in_func == FN_POP_FRONT);
                cmd.take_back  = (in_func == FN_POP_BACK);
                state_nxt      = S_READ;
              end
            end
            FN_SIZE: begin
              cmd.ld_res  = 1'b1;
              cmd.res_src = SRC_SIZE;
            end
            default: begin
              cmd.clear  = 1'b1;
              cmd.ld_res = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        // read data is registered; load it into the result beat
        cmd.ld_res  = 1'b1;
        cmd.res_src = SRC_MEM;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd.ld_res) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* design/deq_dp.sv */
// Datapath for the double-ended queue: circular buffer, head/count, result beat.
// Depends on deq_pkg.
module deq_dp
  import deq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  deq_cmd_t    cmd,
  input  logic [31:0] wr_value,
  output deq_stat_t   stat,
  output logic [1:0]  res_status,
  output logic [31:0] res_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);
  localparam logic [SW-1:0] DEP_S = SW'(DEPTH);

  logic [31:0]   mem [DEPTH];
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0]   rd_data_r;
  logic [1:0]    status_r, status_nxt;
  logic [31:0]   data_r, data_nxt;

  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail_slot, back_slot, prev_head, next_head;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          wr_en;

  // tail = first free slot behind the back entry
  always_comb begin
    tail_sum = SW'(head_r) + SW'(count_r);
    if (tail_sum >= DEP_S) tail_sum = tail_sum - DEP_S;
    tail_slot = AW'(tail_sum);
  end

  assign back_slot = (tail_slot == '0) ? LAST : tail_slot - AW'(1);
  assign prev_head = (head_r == '0) ? LAST : head_r - AW'(1);
  assign next_head = (head_r == LAST) ? '0 : head_r + AW'(1);

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(DEPTH));

  assign wr_en   = cmd.put_back || cmd.put_front;
  assign wr_addr = cmd.put_front ? prev_head : tail_slot;
  assign rd_addr = cmd.rd_back ? back_slot : head_r;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.clear) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else begin
      if (cmd.put_front)  head_nxt = prev_head;
      if (cmd.take_front) head_nxt = next_head;
      if (wr_en) count_nxt = count_r + CW'(1);
      if (cmd.take_front || cmd.take_back) count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    status_nxt = status_r;
    data_nxt   = data_r;
    if (cmd.ld_res) begin
      case (cmd.res_src)
        SRC_ERR: begin
          status_nxt = ST_ERROR;
          data_nxt   = '0;
        end
        SRC_SIZE: begin
          status_nxt = ST_DATA;
          data_nxt   = 32'(count_r);
        end
        SRC_MEM: begin
          status_nxt = ST_DATA;
          data_nxt   = rd_data_r;
        end
        default: begin
          status_nxt = ST_OK;
          data_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_value;
    if (cmd.rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    data_r   <= data_nxt;
  end

  assign res_status = status_r;
  assign res_data   = data_r;

endmodule

/* design/double_ended_queue.sv */
// Top level of the double-ended queue of signed 32-bit values.
// Depends on deq_pkg, deq_ctrl and deq_dp.
//
//  channel | beat carries                     | direction
//  in_     | tuser: func, tdata: value        | request in
//  out_    | tuser: status, tdata: data       | result out
//
// Push, size, clear and refused requests load the output register directly;
// a pop or peek on a non-empty queue goes through the memory read register first.
// Results sit in an output register; a new request is taken while it drains.
// A stalled result holds the input off once the output register is full.
// Synchronous active-low reset empties the queue; entry memory is not cleared.
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // [2:0] func
  input  logic [31:0] in_tdata,   // [31:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic [31:0] out_tdata   // [31:0] data
);

  deq_cmd_t  cmd;
  deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .wr_value   (in_tdata),
    .stat       (stat),
    .res_status (out_tuser),
    .res_data   (out_tdata)
  );

  logic acc;
  assign acc = in_tvalid && in_tready;

  a_not_empty_and_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.empty && stat.full))
    else $error("queue flagged both empty and full");

  a_size_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_tuser == FN_SIZE) |=> out_tvalid && (out_tuser == ST_DATA))
    else $error("size request did not give a data beat");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    acc && stat.full && ((in_tuser == FN_PUSH_BACK) || (in_tuser == FN_PUSH_FRONT))
    |=> out_tvalid && (out_tuser == ST_ERROR) && (out_tdata == '0) && stat.full)
    else $error("push on full queue not refused");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_tuser == FN_CLEAR) |=> stat.empty && (out_tuser == ST_OK))
    else $error("clear did not empty the queue");

endmodule
